// File: rtl/dqd_pkg.sv
// shared types and codes for the double-ended queue with delete by value
`default_nettype none

package dqd_pkg;

  // default number of entries
  localparam int unsigned DEPTH_DEFAULT = 16;

  // request codes
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_DELETE     = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // request item
  typedef struct packed {
    logic [2:0]          mode;
    logic signed [31:0]  value;
  } req_t;

  // result item
  typedef struct packed {
    logic signed [31:0]  result_value;
    logic [1:0]          status;
    logic [4:0]          occupancy;
  } rsp_t;

  // operation broadcast to every cell, pushes and pops already gated by full/empty
  typedef struct packed {
    logic         push_front;
    logic         push_back;
    logic         pop_front;
    logic         pop_back;
    logic         del;
    logic [31:0]  value;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/dqd_cell.sv
// one storage cell of the queue chain, front is the low index
`default_nettype none

module dqd_cell (
  input  logic               clk,
  input  logic               rst,
  input  dqd_pkg::cell_ctl_t ctl,
  input  logic [31:0]        left_data,
  input  logic               left_valid,
  input  logic [31:0]        right_data,
  input  logic               right_valid,
  input  logic               hit_in,
  output logic               hit_out,
  input  logic [31:0]        tail_in,
  output logic [31:0]        tail_out,
  output logic [31:0]        data_out,
  output logic               valid_out
);
  import dqd_pkg::*;

  logic [31:0] data;
  logic        valid;
  logic [31:0] data_next;
  logic        valid_next;
  logic        is_tail;

  // first-match search ripples from the front
  assign hit_out = hit_in | (valid && (data == ctl.value));

  // last held entry hands its value toward the front
  assign is_tail  = valid && !right_valid;
  assign tail_out = is_tail ? data : tail_in;

  assign data_out  = data;
  assign valid_out = valid;

  // next contents from the broadcast operation
  always_comb begin
    data_next  = data;
    valid_next = valid;
    if (ctl.push_front) begin
      data_next  = left_data;
      valid_next = left_valid;
    end else if (ctl.push_back) begin
      if (!valid && left_valid) begin
        data_next  = ctl.value;
        valid_next = 1'b1;
      end
    end else if (ctl.pop_front) begin
      data_next  = right_data;
      valid_next = right_valid;
    end else if (ctl.pop_back) begin
      if (is_tail) begin
        valid_next = 1'b0;
      end
    end else if (ctl.del) begin
      if (hit_out) begin
        data_next  = right_data;
        valid_next = right_valid;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    data <= data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/deque_with_delete_by_value.sv
// top level: bounded double-ended queue of 32-bit values with delete by value
`default_nettype none

// Usage:
// A request item (mode, value) is taken at a rising edge where start is high
// and busy is low. busy stays low: a new item may come in every cycle.
// Modes: push front, push back, pop front, pop back, delete first match
// searched from the front.
// Each item gives one result in the cycle after it is taken: done is high for
// exactly one cycle with rsp holding the value moved, a status (ok, empty or
// not found, full) and the occupancy after the item. The receiver cannot stall.
// Throughput is one item per cycle. The entries sit in a
// row of DEPTH cells; every item shifts the row by at most one place, and a
// delete finds its match through a priority chain running across the cells.
// Reset clears the valid bit of every cell and the count, leaving the queue
// empty; cell contents are not cleared.
module deque_with_delete_by_value #(
  parameter int unsigned DEPTH = dqd_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  dqd_pkg::req_t  req,
  output logic           done,
  output dqd_pkg::rsp_t  rsp
);
  import dqd_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic              accept;
  logic [CntW-1:0]   count;
  logic [CntW-1:0]   count_next;
  logic [CntW+4:0]   count_wide;
  logic              full;
  logic              empty;
  cell_ctl_t         ctl;
  rsp_t              rsp_next;

  logic [31:0]       cell_data  [DEPTH];
  logic [DEPTH-1:0]  cell_valid;
  logic [DEPTH:0]    hit_chain;
  logic [31:0]       tail_chain [DEPTH+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CntW'(DEPTH));
  assign empty  = (count == '0);

  // decode the request into a gated cell operation
  always_comb begin
    ctl = '0;
    ctl.value = req.value;
    if (accept) begin
      unique case (req.mode)
        MODE_PUSH_FRONT: ctl.push_front = !full;
        MODE_PUSH_BACK:  ctl.push_back  = !full;
        MODE_POP_FRONT:  ctl.pop_front  = !empty;
        MODE_POP_BACK:   ctl.pop_back   = !empty;
        MODE_DELETE:     ctl.del        = 1'b1;
        default:         ctl.del        = 1'b0;
      endcase
    end
  end

  // chain ends
  assign hit_chain[0]      = 1'b0;
  assign tail_chain[DEPTH] = '0;

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] left_data;
    logic        left_valid;
    logic [31:0] right_data;
    logic        right_valid;

    if (i == 0) begin : g_front
      assign left_data  = req.value;
      assign left_valid = 1'b1;
    end else begin : g_inner_left
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    dqd_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_data   (left_data),
      .left_valid  (left_valid),
      .right_data  (right_data),
      .right_valid (right_valid),
      .hit_in      (hit_chain[i]),
      .hit_out     (hit_chain[i+1]),
      .tail_in     (tail_chain[i+1]),
      .tail_out    (tail_chain[i]),
      .data_out    (cell_data[i]),
      .valid_out   (cell_valid[i])
    );
  end

  // result and next count
  always_comb begin
    count_next = count;
    rsp_next   = '0;
    rsp_next.status = ST_OK;
    case (req.mode) inside
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        rsp_next.result_value = req.value;
        if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          count_next = count + CntW'(1);
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (empty) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          rsp_next.result_value = (req.mode == MODE_POP_FRONT) ?
                                  cell_data[0] : tail_chain[0];
          count_next = count - CntW'(1);
        end
      end
      MODE_DELETE: begin
        if (hit_chain[DEPTH]) begin
          rsp_next.result_value = req.value;
          count_next = count - CntW'(1);
        end else begin
          rsp_next.status = ST_EMPTY;
        end
      end
      default: begin
        rsp_next.result_value = '0;
      end
    endcase
    count_wide = (CntW + 5)'(count_next);
    rsp_next.occupancy = count_wide[4:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

`ifndef SYNTHESIS
  // count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("queue count exceeds depth");

  // held entries in the cell row always match the count
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("cell valid bits disagree with count");

  // every taken item yields exactly one result in the next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("missing result strobe");

  a_no_extra_done: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("result strobe without an item");
`endif

endmodule

`default_nettype wire

// File: sim/tb.sv
// testbench for the deque with delete by value: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module tb;
  import dqd_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEFAULT;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 100;

  // request codes the block leaves unused
  localparam logic [2:0] MODE_SPARE_A = 3'd5;
  localparam logic [2:0] MODE_SPARE_B = 3'd6;
  localparam logic [2:0] MODE_SPARE_C = 3'd7;

  typedef struct {
    req_t item;
    int   gap;
    bit   hold;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  pending_t pending_items[$];
  rsp_t     expected_rsp[$];

  // predictor state: front at index 0
  logic signed [31:0] dq_entries [DEPTH];
  int unsigned        dq_count = 0;

  int err_count = 0;
  int items_taken = 0;
  int results_seen = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_miss = 0;
  int n_deleted = 0;
  int peak_count = 0;
  int idle_left = 0;
  int cur_gap = 0;
  int idle_cycles = 0;

  deque_with_delete_by_value #(.DEPTH(DEPTH)) DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one request to the predicted deque and return its result
  function automatic rsp_t apply_request(req_t r);
    rsp_t        o;
    int unsigned hit;
    o.result_value = '0;
    o.status = ST_OK;
    case (r.mode) inside
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        o.result_value = r.value;
        if (dq_count >= DEPTH) begin
          o.status = ST_FULL;
          n_full++;
        end else if (r.mode == MODE_PUSH_FRONT) begin
          for (int i = DEPTH - 1; i > 0; i--) dq_entries[i] = dq_entries[i - 1];
          dq_entries[0] = r.value;
          dq_count++;
        end else begin
          dq_entries[dq_count] = r.value;
          dq_count++;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (dq_count == 0) begin
          o.status = ST_EMPTY;
          n_empty++;
        end else if (r.mode == MODE_POP_FRONT) begin
          o.result_value = dq_entries[0];
          for (int i = 0; i + 1 < dq_count; i++) dq_entries[i] = dq_entries[i + 1];
          dq_count--;
        end else begin
          o.result_value = dq_entries[dq_count - 1];
          dq_count--;
        end
      end
      MODE_DELETE: begin
        // first match searched from the front
        hit = dq_count;
        for (int i = 0; i < dq_count; i++) begin
          if (hit == dq_count && dq_entries[i] == r.value) hit = i;
        end
        if (hit == dq_count) begin
          o.status = ST_EMPTY;
          n_miss++;
        end else begin
          o.result_value = r.value;
          for (int i = hit; i + 1 < dq_count; i++) dq_entries[i] = dq_entries[i + 1];
          dq_count--;
          n_deleted++;
        end
      end
      default: ;
    endcase
    o.occupancy = dq_count[4:0];
    if (dq_count > peak_count) peak_count = dq_count;
    return o;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    err_count++;
    $display("%0t mismatch on %s: got %08h want %08h", $time, field, got, want);
  endtask

  // idle cycles before the next item: mostly short, a few long
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // values: a small pool so deletes hit and duplicates occur, extremes, full random
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $signed(32'($urandom_range(0, 8))) - 32'sd4;
    if (r < 60) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $signed($urandom);
  endfunction

  function automatic logic [2:0] pick_mode(int push_w, int pop_w, int del_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_w) return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
    if (r < push_w + pop_w) return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
    if (r < push_w + pop_w + del_w) return MODE_DELETE;
    case ($urandom_range(0, 2))
      0: return MODE_SPARE_A;
      1: return MODE_SPARE_B;
      default: return MODE_SPARE_C;
    endcase
  endfunction

  task automatic queue_item(input logic [2:0] mode, input logic signed [31:0] value,
                            input int gap);
    pending_t p;
    p.item.mode = mode;
    p.item.value = value;
    p.gap = gap;
    p.hold = 1'b0;
    pending_items.push_back(p);
  endtask

  // sender waits here until every result is back
  task automatic queue_hold();
    pending_t p;
    p.item = '0;
    p.gap = 0;
    p.hold = 1'b1;
    pending_items.push_back(p);
  endtask

  // driver: present items from the pending queue, predict on acceptance
  always @(posedge clk) begin : drive_items
    logic     nxt_start;
    req_t     nxt_req;
    pending_t p;
    nxt_start = start;
    nxt_req = req;
    if (rst) begin
      nxt_start = 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        expected_rsp.push_back(apply_request(req));
        items_taken++;
        idle_left = cur_gap;
        nxt_start = 1'b0;
      end
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left--;
          nxt_start = 1'b0;
        end else if (pending_items.size() != 0) begin
          p = pending_items[0];
          if (p.hold) begin
            if (expected_rsp.size() == 0) void'(pending_items.pop_front());
            nxt_start = 1'b0;
          end else begin
            void'(pending_items.pop_front());
            nxt_start = 1'b1;
            nxt_req = p.item;
            cur_gap = p.gap;
          end
        end
      end
    end
    start <= nxt_start;
    req <= nxt_req;
  end

  // monitor: every result against the oldest prediction
  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        report("result with no item outstanding", rsp.result_value, '0);
      end else begin
        want = expected_rsp.pop_front();
        results_seen++;
        if (rsp.result_value !== want.result_value)
          report("result_value", rsp.result_value, want.result_value);
        if (rsp.status !== want.status)
          report("status", 32'(rsp.status), 32'(want.status));
        if (rsp.occupancy !== want.occupancy)
          report("occupancy", 32'(rsp.occupancy), 32'(want.occupancy));
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("watchdog: no item or result for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    int push_w;
    int pop_w;
    int del_w;
    bit burst;

    // empty queue: pops and delete report empty, spare code ignored
    queue_item(MODE_POP_FRONT, 32'sd7, 0);
    queue_item(MODE_POP_BACK, -32'sd7, 1);
    queue_item(MODE_DELETE, 32'sd0, 0);
    queue_item(MODE_SPARE_A, 32'sh7fff_ffff, 0);
    // field extremes, order [0, max, min, -1]
    queue_item(MODE_PUSH_BACK, 32'sh8000_0000, 0);
    queue_item(MODE_PUSH_FRONT, 32'sh7fff_ffff, 2);
    queue_item(MODE_PUSH_BACK, -32'sd1, 0);
    queue_item(MODE_PUSH_FRONT, 32'sd0, 0);
    // delete a missing value, then one from the middle
    queue_item(MODE_DELETE, 32'sd12345, 0);
    queue_item(MODE_DELETE, 32'sh7fff_ffff, 0);
    queue_item(MODE_SPARE_B, 32'sd0, 0);
    queue_item(MODE_SPARE_C, -32'sd1, 0);
    // pops down to a single entry, then pop back of that entry
    queue_item(MODE_POP_FRONT, 32'sd0, 0);
    queue_item(MODE_POP_BACK, 32'sd0, 3);
    queue_item(MODE_POP_BACK, 32'sd0, 0);
    // fill with duplicates, then pushes at both ends rejected when full
    for (int i = 0; i < DEPTH; i++) queue_item(MODE_PUSH_BACK, 32'(i % 5), 0);
    queue_item(MODE_PUSH_FRONT, 32'sd99, 0);
    queue_item(MODE_PUSH_BACK, 32'sh8000_0000, 0);
    queue_hold();

    // random phases: push-heavy, pop-heavy, balanced, delete-heavy
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin push_w = 70; pop_w = 15; del_w = 12; end
        1: begin push_w = 20; pop_w = 65; del_w = 12; end
        2: begin push_w = 45; pop_w = 35; del_w = 17; end
        default: begin push_w = 40; pop_w = 15; del_w = 42; end
      endcase
      burst = (ph % 2) == 1;
      for (int k = 0; k < PHASE_ITEMS; k++)
        queue_item(pick_mode(push_w, pop_w, del_w), pick_value(), pick_gap(burst));
      queue_hold();
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (pending_items.size() != 0 || start || expected_rsp.size() != 0) @(posedge clk);
    // results are registered: keep watching for stray results before the summary
    repeat (4) @(posedge clk);

    $display("covered %0d requests, %0d results checked, peak occupancy %0d",
             items_taken, results_seen, peak_count);
    $display("full rejects %0d, empty pops %0d, delete hits %0d, delete misses %0d",
             n_full, n_empty, n_deleted, n_miss);
    if (err_count == 0 && expected_rsp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
